// ----- hdl/trig_basis_function_eval_defines.svh -----
// Assertion macros for the trigonometric basis function evaluator.
// Used by the RTL files in this folder; needs aclk and aresetn in scope.
`ifndef TRIG_BASIS_FUNCTION_EVAL_DEFINES_SVH
`define TRIG_BASIS_FUNCTION_EVAL_DEFINES_SVH

// Condition in a cycle implies consequence in the same cycle.
`define TBF_ASSERT_SAME(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (conseq)) else $error(msg);

// Condition in a cycle implies consequence in the next cycle.
`define TBF_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);

`endif

// ----- hdl/tbf_pkg.sv -----
// Shared widths, register indices and constant tables for the
// trigonometric basis function evaluator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tbf_pkg;

    localparam int MAX_BASIS_DEF = 1023;

    localparam int NUM_W   = 10;
    localparam int CA_W    = 17;
    localparam int CB_W    = 16;
    localparam int K_W     = 10;
    localparam int X_W     = 32;
    localparam int MODE_W  = 3;
    localparam int OUT_W   = 62;
    localparam int TDATA_OUT_W = 64;

    localparam int CORDIC_STEPS = 30;
    localparam int CXY_W   = 34;
    localparam int Z_W     = 33;
    localparam int KPOW_W  = 40;
    localparam int PIPOW_W = 26;
    localparam int W_W     = 64;
    localparam int CW_W    = 81;
    localparam int SABS_W  = 33;
    localparam int PART_W  = 27;
    localparam int MAG_W   = 114;
    localparam int TERM_W  = 115;
    localparam int ACC_W   = 118;
    localparam int OUT_SHIFT = 49;
    localparam int ROUND_BIT = 48;

    // Lane depth: input register, two set-up stages, 30 rotations with the
    // coefficient stages overlapped, and four product stages.
    localparam int LANE_LAT = 37;

    localparam logic [CXY_W-1:0] CORDIC_START = 34'd652032874;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_BASIS  = 2'd0;
    localparam logic [1:0] REG_COEF_A = 2'd1;
    localparam logic [1:0] REG_COEF_B = 2'd2;

    localparam logic [29:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1
    };

    // pi^m in Q.19; orders beyond four give zero.
    function automatic logic [PIPOW_W-1:0] pi_pow(input logic [MODE_W-1:0] m);
        logic [PIPOW_W-1:0] r;
        case (m)
            3'd0:    r = 26'd524288;
            3'd1:    r = 26'd1647099;
            3'd2:    r = 26'd5174515;
            3'd3:    r = 26'd16256219;
            3'd4:    r = 26'd51070418;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tbf_term_lane.sv -----
// One weighted term c * (k*pi)^m * sin(k*pi*x + q quarter turns), as a
// fully pipelined lane with a 30-stage CORDIC. Depends on tbf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbf_term_lane
    import tbf_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [K_W-1:0]           k_in,
    input  wire logic [CA_W-1:0]          c_in,
    input  wire logic [X_W-1:0]           x_in,
    input  wire logic [1:0]               q_in,
    input  wire logic [MODE_W-1:0]        mode_in,
    output logic signed [TERM_W-1:0]      term_out
);

    localparam int CW_DLY = 27;

    // t0
    logic [K_W-1:0]    k0_reg;
    logic [CA_W-1:0]   c0_reg;
    logic [X_W-1:0]    x0_reg;
    logic [1:0]        q0_reg;
    logic [MODE_W-1:0] m0_reg;
    // t1
    logic [31:0]       ang1_reg;
    logic [K_W-1:0]    k1_reg;
    logic [2*K_W-1:0]  ksq1_reg;
    logic [CA_W-1:0]   c1_reg;
    logic [MODE_W-1:0] m1_reg;
    // t2
    logic signed [Z_W-1:0] z2_reg;
    logic              flip2_reg;
    logic [KPOW_W-1:0] kpow2_reg;
    logic [CA_W-1:0]   c2_reg;
    logic [MODE_W-1:0] m2_reg;
    // coefficient path
    logic [W_W-1:0]    w3_reg;
    logic [CA_W-1:0]   c3_reg;
    logic [48:0]       cwl4_reg, cwh4_reg;
    logic [CW_W-1:0]   cw5_reg;
    logic [CW_W-1:0]   cw_d_reg [0:CW_DLY-1];
    // rotations
    logic signed [CXY_W-1:0] cx_reg [0:CORDIC_STEPS-1];
    logic signed [CXY_W-1:0] cy_reg [0:CORDIC_STEPS-1];
    logic signed [Z_W-1:0]   z_reg  [0:CORDIC_STEPS-1];
    logic                    flip_reg [0:CORDIC_STEPS-1];
    // products
    logic [SABS_W-1:0] sabs33_reg;
    logic              neg33_reg;
    logic [CW_W-1:0]   cw33_reg;
    logic [SABS_W+PART_W-1:0] p0_34_reg, p1_34_reg, p2_34_reg;
    logic              neg34_reg;
    logic [MAG_W-1:0]  mag35_reg;
    logic              neg35_reg;

    logic [K_W+X_W-1:0]  kx_full;
    logic [31:0]         ang1_next;
    logic [31:0]         ang_red;
    logic                flip2_next;
    logic [KPOW_W-1:0]   kpow2_next;
    logic [W_W+2-1:0]    w_full;
    logic signed [CXY_W-1:0] s_final;
    logic [CXY_W-1:0]    s_abs;

    assign kx_full   = {{X_W{1'b0}}, k0_reg} * {{K_W{1'b0}}, x0_reg};
    assign ang1_next = {kx_full[30:0], 1'b0} + {q0_reg, 30'b0};

    // fold the left half-turn onto the right one and negate at the end
    assign flip2_next = (ang1_reg[31:30] == 2'b01) || (ang1_reg[31:30] == 2'b10);
    assign ang_red    = flip2_next ? (ang1_reg ^ 32'h8000_0000) : ang1_reg;

    always_comb begin
        case (m1_reg)
            3'd0:    kpow2_next = KPOW_W'(1);
            3'd1:    kpow2_next = KPOW_W'(k1_reg);
            3'd2:    kpow2_next = KPOW_W'(ksq1_reg);
            3'd3:    kpow2_next = {20'b0, ksq1_reg} * {30'b0, k1_reg};
            3'd4:    kpow2_next = KPOW_W'({20'b0, ksq1_reg} * {20'b0, ksq1_reg});
            default: kpow2_next = '0;
        endcase
    end

    assign w_full = {26'b0, kpow2_reg} * {{KPOW_W{1'b0}}, pi_pow(m2_reg)};

    always_ff @(posedge aclk) begin
        if (en) begin
            k0_reg   <= k_in;
            c0_reg   <= c_in;
            x0_reg   <= x_in;
            q0_reg   <= q_in;
            m0_reg   <= mode_in;

            ang1_reg <= ang1_next;
            k1_reg   <= k0_reg;
            ksq1_reg <= {{K_W{1'b0}}, k0_reg} * {{K_W{1'b0}}, k0_reg};
            c1_reg   <= c0_reg;
            m1_reg   <= m0_reg;

            z2_reg    <= Z_W'($signed(ang_red));
            flip2_reg <= flip2_next;
            kpow2_reg <= kpow2_next;
            c2_reg    <= c1_reg;
            m2_reg    <= m1_reg;

            w3_reg   <= w_full[W_W-1:0];
            c3_reg   <= c2_reg;
            cwl4_reg <= {32'b0, c3_reg} * {17'b0, w3_reg[31:0]};
            cwh4_reg <= {32'b0, c3_reg} * {17'b0, w3_reg[63:32]};
            cw5_reg  <= CW_W'(cwl4_reg) + (CW_W'(cwh4_reg) << 32);
            cw_d_reg[0] <= cw5_reg;
        end
    end

    for (genvar d = 1; d < CW_DLY; d++) begin : g_cw_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                cw_d_reg[d] <= cw_d_reg[d-1];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [CXY_W-1:0] cx_in, cy_in, dx, dy;
        logic signed [Z_W-1:0]   z_in, at;
        logic                    f_in;
        if (i == 0) begin : g_first
            assign cx_in = $signed(CORDIC_START);
            assign cy_in = '0;
            assign z_in  = z2_reg;
            assign f_in  = flip2_reg;
        end else begin : g_rest
            assign cx_in = cx_reg[i-1];
            assign cy_in = cy_reg[i-1];
            assign z_in  = z_reg[i-1];
            assign f_in  = flip_reg[i-1];
        end
        assign dx = cy_in >>> i;
        assign dy = cx_in >>> i;
        assign at = $signed({3'b0, ATAN_TAB[i]});
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_in >= 0) begin
                    cx_reg[i] <= cx_in - dx;
                    cy_reg[i] <= cy_in + dy;
                    z_reg[i]  <= z_in - at;
                end else begin
                    cx_reg[i] <= cx_in + dx;
                    cy_reg[i] <= cy_in - dy;
                    z_reg[i]  <= z_in + at;
                end
                flip_reg[i] <= f_in;
            end
        end
    end

    assign s_final = flip_reg[CORDIC_STEPS-1] ? -cy_reg[CORDIC_STEPS-1]
                                              : cy_reg[CORDIC_STEPS-1];
    assign s_abs   = s_final[CXY_W-1] ? CXY_W'(-s_final) : CXY_W'(s_final);

    always_ff @(posedge aclk) begin
        if (en) begin
            sabs33_reg <= s_abs[SABS_W-1:0];
            neg33_reg  <= s_final[CXY_W-1];
            cw33_reg   <= cw_d_reg[CW_DLY-1];

            p0_34_reg <= {27'b0, sabs33_reg} * {33'b0, cw33_reg[26:0]};
            p1_34_reg <= {27'b0, sabs33_reg} * {33'b0, cw33_reg[53:27]};
            p2_34_reg <= {27'b0, sabs33_reg} * {33'b0, cw33_reg[80:54]};
            neg34_reg <= neg33_reg;

            mag35_reg <= MAG_W'(p0_34_reg) + (MAG_W'(p1_34_reg) << 27)
                       + (MAG_W'(p2_34_reg) << 54);
            neg35_reg <= neg34_reg;

            term_out  <= neg35_reg ? -$signed({1'b0, mag35_reg})
                                   : $signed({1'b0, mag35_reg});
        end
    end

endmodule
`default_nettype wire

// ----- hdl/trig_basis_function_eval.sv -----
// Top level of the trigonometric basis function evaluator: register
// port, stream handshake, three term lanes and the rounding stage.
// Depends on tbf_pkg, tbf_term_lane and the assertion macro header.
//
// Usage: load basis_number, coef_a and coef_b over the APB port while the
// block is idle. Each slave transaction carries an evaluation point x in
// Q1.30 (s_tdata) and a derivative order 0..4 (s_tuser); each master
// transaction carries the Q45.16 value, saturated, in m_tdata[61:0].
// Orders five to seven give zero.
// An accepted transaction passes through the input register, the lane
// set-up stages, the 30 CORDIC rotation stages and the product, sum and
// rounding stages. Throughput: one transaction per cycle unless stalled.
// The whole pipeline advances together; when the output register holds a
// result that is not taken, s_tready drops and every stage holds, so
// nothing is lost or repeated. Synchronous reset clears the valid bits and
// the configuration registers, not the data path; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "trig_basis_function_eval_defines.svh"
module trig_basis_function_eval
    import tbf_pkg::*;
#(
    parameter int MAX_BASIS = MAX_BASIS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // APB configuration
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [X_W-1:0]          s_tdata,   // [31:0] x_point
    input  wire logic [MODE_W-1:0]       s_tuser,   // [2:0] mode
    // result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [TDATA_OUT_W-1:0]       m_tdata    // [61:0] result_value
);

    localparam int VLD_N = LANE_LAT + 2;

    logic [NUM_W-1:0] basis_reg;
    logic [CA_W-1:0]  coef_a_reg;
    logic [CB_W-1:0]  coef_b_reg;

    logic                en;
    logic [VLD_N-1:0]    vld_reg;
    logic [X_W-1:0]      x_in_reg;
    logic [MODE_W-1:0]   mode_in_reg;

    logic [NUM_W-1:0]    num_eff;
    logic                odd;
    logic [K_W-1:0]      k_half;
    logic [K_W-1:0]      k0, k1, k2;
    logic [CA_W-1:0]     c0, c1, c2;
    logic [1:0]          quarters;

    logic signed [TERM_W-1:0] term0, term1, term2;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-OUT_SHIFT-1:0] q_shift;
    logic [OUT_W-1:0]         res_next;
    logic                     m_tvalid_reg;
    logic [TDATA_OUT_W-1:0]   m_tdata_reg;

    logic       wr_en;
    logic [1:0] reg_idx;

    // configuration
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            basis_reg  <= '0;
            coef_a_reg <= '0;
            coef_b_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BASIS:  basis_reg  <= pwdata[NUM_W-1:0];
                REG_COEF_A: coef_a_reg <= pwdata[CA_W-1:0];
                REG_COEF_B: coef_b_reg <= pwdata[CB_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BASIS:  prdata = {{(32-NUM_W){1'b0}}, basis_reg};
            REG_COEF_A: prdata = {{(32-CA_W){1'b0}}, coef_a_reg};
            REG_COEF_B: prdata = {{(32-CB_W){1'b0}}, coef_b_reg};
            default:    prdata = '0;
        endcase
    end

    // pipeline control: advance unless a finished result is stuck
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VLD_N-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_in_reg    <= s_tdata;
            mode_in_reg <= s_tuser;
        end
    end

    // term set-up: cosine for an even basis, three sines for an odd one
    assign num_eff  = ({3'b0, basis_reg} > 13'(MAX_BASIS)) ? NUM_W'(MAX_BASIS)
                                                           : basis_reg;
    assign odd      = num_eff[0];
    assign k_half   = K_W'(num_eff >> 1);
    assign k0       = odd ? k_half + K_W'(1) : k_half;
    assign k1       = k_half + K_W'(2);
    assign k2       = k_half + K_W'(3);
    assign c0       = ONE_Q16;
    assign c1       = odd ? coef_a_reg : '0;
    assign c2       = odd ? {1'b0, coef_b_reg} : '0;
    assign quarters = mode_in_reg[1:0] + {1'b0, !odd};

    tbf_term_lane u_lane0 (
        .aclk(aclk), .en(en), .k_in(k0), .c_in(c0), .x_in(x_in_reg),
        .q_in(quarters), .mode_in(mode_in_reg), .term_out(term0)
    );
    tbf_term_lane u_lane1 (
        .aclk(aclk), .en(en), .k_in(k1), .c_in(c1), .x_in(x_in_reg),
        .q_in(quarters), .mode_in(mode_in_reg), .term_out(term1)
    );
    tbf_term_lane u_lane2 (
        .aclk(aclk), .en(en), .k_in(k2), .c_in(c2), .x_in(x_in_reg),
        .q_in(quarters), .mode_in(mode_in_reg), .term_out(term2)
    );

    // sum, round half up, then saturate to Q45.16
    assign q_shift = acc_reg[ACC_W-1:OUT_SHIFT];

    always_comb begin
        if (q_shift > $signed((ACC_W-OUT_SHIFT)'({1'b0, {(OUT_W-1){1'b1}}}))) begin
            res_next = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (q_shift < -$signed((ACC_W-OUT_SHIFT)'({1'b1, {(OUT_W-1){1'b0}}}))) begin
            res_next = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            res_next = q_shift[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg     <= ACC_W'(term0) + ACC_W'(term1) + ACC_W'(term2)
                         + (ACC_W'(1) << ROUND_BIT);
            m_tdata_reg <= {{(TDATA_OUT_W-OUT_W){1'b0}}, res_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[VLD_N-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TBF_ASSERT_NEXT(a_stall_holds_pipe, !s_tready, $stable(vld_reg), "valid bits moved during a stall")
    `TBF_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0], "accepted transaction not in stage one")
    `TBF_ASSERT_NEXT(a_last_reaches_out, vld_reg[VLD_N-1] && s_tready, m_tvalid, "finished item not presented")
    `TBF_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[TDATA_OUT_W-1:OUT_W] == '0, "padding bits set")

endmodule
`default_nettype wire
